FILE: hw/rtl/msbr_pkg.sv
// Package for the MSB-first bit reader: field widths, command codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package msbr_pkg;

	localparam int CMD_W   = 3;
	localparam int ADDR_W  = 12;
	localparam int BYTE_W  = 8;
	localparam int COUNT_W = 16;
	localparam int VALUE_W = 32;
	localparam int POS_W   = 16;
	localparam int SIZE_W  = 13;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// Register index of buffer_size on the configuration port.
	localparam logic [0:0] REG_BUFFER_SIZE = 1'b0;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE  = 3'd0,
		CMD_READ   = 3'd1,
		CMD_PEEK   = 3'd2,
		CMD_SKIP   = 3'd3,
		CMD_REWIND = 3'd4
	} cmd_e_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_BITS,
		ST_FINISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic fetch;
		logic step;
		logic finish;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic start_bits;
		logic cnt_last;
		logic slot_free;
	} ctrl_stat_t;

endpackage

FILE: hw/rtl/msbr_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module msbr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hw/rtl/msbr_ctrl.sv
// Controller state machine of the MSB-first bit reader.
// Depends on msbr_pkg.
module msbr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  msbr_pkg::ctrl_stat_t stat,
	output msbr_pkg::ctrl_cmd_t  ctl
);

	import msbr_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					ctl.load = 1'b1;
					state_d  = stat.start_bits ? ST_FETCH : ST_FINISH;
				end
			end
			ST_FETCH: begin
				ctl.fetch = 1'b1;
				state_d   = ST_BITS;
			end
			ST_BITS: begin
				ctl.step = 1'b1;
				if (stat.cnt_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (stat.slot_free) begin
					ctl.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_bits_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BITS && stat.cnt_last) |=> (state_q == ST_FINISH))
		else $error("bit loop did not end after its last bit");

	a_fetch_once: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.fetch |=> (ctl.step && !ctl.fetch))
		else $error("first byte fetch not followed by a bit step");

endmodule

FILE: hw/rtl/msbr_dp.sv
// Datapath of the MSB-first bit reader: position and flag, bit shifter,
// byte store and output register.
// Depends on msbr_pkg and msbr_ram.
module msbr_dp #(
	parameter int STORE_BYTES   = 4096,
	parameter int MAX_READ_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [msbr_pkg::SIZE_W-1:0]     buffer_size,
	input  logic [msbr_pkg::CMD_W-1:0]      cmd,
	input  logic [msbr_pkg::ADDR_W-1:0]     byte_address,
	input  logic [msbr_pkg::BYTE_W-1:0]     byte_value,
	input  logic [msbr_pkg::COUNT_W-1:0]    bit_count,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [msbr_pkg::VALUE_W-1:0]    value,
	output logic [msbr_pkg::POS_W-1:0]      bits_remaining,
	output logic                            overrun,
	input  msbr_pkg::ctrl_cmd_t              ctl,
	output msbr_pkg::ctrl_stat_t             stat
);

	import msbr_pkg::*;

	localparam int AW    = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
	localparam int CW    = $clog2(MAX_READ_BITS + 1);
	localparam int LIM_W = 17;
	localparam logic [LIM_W-1:0]   STORE_LIM = LIM_W'(STORE_BYTES);
	localparam logic [COUNT_W-1:0] MAX_CNT   = COUNT_W'(MAX_READ_BITS);

	// Architectural state.
	logic [POS_W-1:0] pos_q;
	logic             over_q;

	// Latched command.
	cmd_e_t             cmd_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [BYTE_W-1:0]  byte_q;
	logic [COUNT_W-1:0] count_q;

	// Working copies for the bit loop.
	logic [POS_W-1:0]   wpos_q;
	logic               wover_q;
	logic [VALUE_W-1:0] val_q;
	logic [CW-1:0]      cnt_q;

	// Output register.
	logic               out_valid_q;
	logic [VALUE_W-1:0] value_q;
	logic [POS_W-1:0]   bits_rem_q;
	logic               overrun_q;

	logic [SIZE_W-1:0]  eff_size;
	logic [POS_W-1:0]   total_bits;
	logic               in_range;
	logic               bit_in;
	logic [POS_W-1:0]   wpos_nxt;
	logic [SIZE_W-1:0]  rd_byte;
	logic [15:0]        rd_byte_ext;
	logic [15:0]        wr_addr_ext;
	logic [AW-1:0]      rd_addr;
	logic [AW-1:0]      wr_addr;
	logic               wr_en;
	logic               rd_en;
	logic [BYTE_W-1:0]  rd_data;
	logic [CW-1:0]      cnt_load;
	logic [LIM_W-1:0]   skip_sum;
	logic [POS_W-1:0]   pos_new;
	logic               over_new;
	logic [POS_W-1:0]   rem_new;
	logic [VALUE_W-1:0] value_new;

	// Sizes above the store depth act as the store depth.
	assign eff_size   = (LIM_W'(buffer_size) > STORE_LIM) ? STORE_LIM[SIZE_W-1:0] : buffer_size;
	assign total_bits = {eff_size, 3'b000};

	assign in_range = (wpos_q[POS_W-1:3] < eff_size);
	assign bit_in   = in_range & rd_data[~wpos_q[2:0]];
	assign wpos_nxt = in_range ? (wpos_q + POS_W'(1)) : wpos_q;

	// The store is read ahead of the bit that needs it.
	assign rd_byte     = ctl.fetch ? wpos_q[POS_W-1:3] : wpos_nxt[POS_W-1:3];
	assign rd_byte_ext = {3'b000, rd_byte};
	assign rd_addr     = rd_byte_ext[AW-1:0];
	assign rd_en       = ctl.fetch | ctl.step;

	assign wr_addr_ext = {4'b0000, addr_q};
	assign wr_addr     = wr_addr_ext[AW-1:0];
	assign wr_en       = ctl.finish && (cmd_q == CMD_WRITE) && (LIM_W'(addr_q) < STORE_LIM);

	assign cnt_load = (bit_count > MAX_CNT) ? CW'(MAX_READ_BITS) : bit_count[CW-1:0];

	assign stat.start_bits = ((cmd_e_t'(cmd) == CMD_READ) || (cmd_e_t'(cmd) == CMD_PEEK))
		&& (bit_count != '0);
	assign stat.cnt_last   = (cnt_q == CW'(1));
	assign stat.slot_free  = !out_valid_q || !out_stall;

	msbr_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (STORE_BYTES),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (byte_q),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// State after the latched command completes.
	always_comb begin
		pos_new   = pos_q;
		over_new  = over_q;
		value_new = '0;
		skip_sum  = LIM_W'(pos_q) + LIM_W'(count_q);
		case (cmd_q)
			CMD_READ: begin
				pos_new   = wpos_q;
				over_new  = wover_q;
				value_new = val_q;
			end
			CMD_PEEK: begin
				value_new = val_q;
			end
			CMD_SKIP: begin
				if (count_q != '0) begin
					if (skip_sum > LIM_W'(total_bits)) begin
						pos_new  = total_bits;
						over_new = 1'b1;
					end else begin
						pos_new = skip_sum[POS_W-1:0];
					end
				end
			end
			CMD_REWIND: begin
				pos_new  = '0;
				over_new = 1'b0;
			end
			default: begin
				pos_new = pos_q;
			end
		endcase
		rem_new = (pos_new >= total_bits) ? '0 : (total_bits - pos_new);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			over_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.finish) begin
				pos_q       <= pos_new;
				over_q      <= over_new;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q   <= cmd_e_t'(cmd);
			addr_q  <= byte_address;
			byte_q  <= byte_value;
			count_q <= bit_count;
			wpos_q  <= pos_q;
			wover_q <= over_q;
			val_q   <= '0;
			cnt_q   <= cnt_load;
		end else if (ctl.step) begin
			wpos_q  <= wpos_nxt;
			wover_q <= wover_q | !in_range;
			val_q   <= {val_q[VALUE_W-2:0], bit_in};
			cnt_q   <= cnt_q - CW'(1);
		end
		if (ctl.finish) begin
			value_q    <= value_new;
			bits_rem_q <= rem_new;
			overrun_q  <= over_new;
		end
	end

	assign out_valid      = out_valid_q;
	assign value          = value_q;
	assign bits_remaining = bits_rem_q;
	assign overrun        = overrun_q;

	a_peek_keeps_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.finish && cmd_q == CMD_PEEK) |=> ($stable(pos_q) && $stable(over_q)))
		else $error("peek changed the position or the overrun flag");

	a_flag_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(over_q) |-> $past(ctl.finish && (cmd_q == CMD_READ || cmd_q == CMD_SKIP)))
		else $error("overrun flag set by a command other than read or skip");

	a_step_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.step |-> (cnt_q != '0))
		else $error("bit step with no bits left to take");

endmodule

FILE: hw/rtl/msb_first_bit_reader.sv
// Top level of the MSB-first bit reader: configuration register, controller
// and datapath. Depends on msbr_pkg, msbr_ctrl, msbr_dp (and through it msbr_ram).
//
//  Channel   Direction  Handshake              Payload
//  input     in         in_valid / in_stall    cmd, byte_address, byte_value, bit_count
//  output    out        out_valid / out_stall  value, bits_remaining, overrun
//  config    in         APB psel/penable       paddr, pwdata -> buffer_size
//
// A write byte, skip, rewind, unknown or zero-count word goes from acceptance
// straight to the finish state, which loads the output register, and the next word
// is taken once the block is back in idle. A read or peek of n bits (n clamped to
// MAX_READ_BITS) passes through the fetch state, the bit loop and the finish state
// before it reaches the output register: the bit loop takes one bit per cycle from
// the byte store, whose read port runs one bit position ahead.
// Reset clears the position, the overrun flag, buffer_size and the output valid;
// the byte store has no reset and holds garbage until written. A stalled output
// holds its word while the next input word is accepted and worked on; that word
// then waits in its final state until the output register is free.
module msb_first_bit_reader #(
	parameter int STORE_BYTES   = 4096,
	parameter int MAX_READ_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [msbr_pkg::CMD_W-1:0]      cmd,
	input  logic [msbr_pkg::ADDR_W-1:0]     byte_address,
	input  logic [msbr_pkg::BYTE_W-1:0]     byte_value,
	input  logic [msbr_pkg::COUNT_W-1:0]    bit_count,

	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [msbr_pkg::VALUE_W-1:0]    value,
	output logic [msbr_pkg::POS_W-1:0]      bits_remaining,
	output logic                            overrun,

	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [msbr_pkg::PADDR_W-1:0]    paddr,
	input  logic [msbr_pkg::PDATA_W-1:0]    pwdata,
	output logic [msbr_pkg::PDATA_W-1:0]    prdata,
	output logic                            pready
);

	import msbr_pkg::*;

	logic [SIZE_W-1:0] buffer_size_q;
	logic              reg_sel;
	ctrl_cmd_t         ctl;
	ctrl_stat_t        stat;

	// One register, buffer_size, at byte address zero; word addresses above it read zero.
	assign reg_sel = (paddr[PADDR_W-1:2] == REG_BUFFER_SIZE);
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? PDATA_W'(buffer_size_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_size_q <= '0;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			buffer_size_q <= pwdata[SIZE_W-1:0];
		end
	end

	msbr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.ctl      (ctl)
	);

	msbr_dp #(
		.STORE_BYTES   (STORE_BYTES),
		.MAX_READ_BITS (MAX_READ_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.buffer_size    (buffer_size_q),
		.cmd            (cmd),
		.byte_address   (byte_address),
		.byte_value     (byte_value),
		.bit_count      (bit_count),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.value          (value),
		.bits_remaining (bits_remaining),
		.overrun        (overrun),
		.ctl            (ctl),
		.stat           (stat)
	);

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for msb_first_bit_reader: directed table, then random phases.
// Predicts result words from a shadow copy of the store, position and flag; directed rows may give their word directly.
// Depends on msbr_pkg and the msb_first_bit_reader RTL only.
`timescale 1ns / 100ps

module tb_top;
	import msbr_pkg::*;

	localparam int STORE_BYTES   = 4096;
	localparam int MAX_READ_BITS = 32;

	// Command codes that the block does not decode.
	localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
	localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

	// buffer_size is register 0, so it sits at byte address 4 * 0.
	localparam logic [PADDR_W-1:0] SIZE_REG_ADDR = PADDR_W'(4 * REG_BUFFER_SIZE);

	localparam int PHASES          = 8;
	localparam int WORDS_PER_PHASE = 112;

	// One result word as the output channel presents it.
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [POS_W-1:0]   remaining;
		logic               overrun;
	} status_t;

	typedef enum logic {ROW_WORD, ROW_SIZE} row_kind_t;

	// A row of the directed table: either an input word or a new buffer_size.
	// For a size row the count field carries the size.
	typedef struct {
		row_kind_t            kind;
		logic [CMD_W-1:0]     op;
		logic [ADDR_W-1:0]    addr;
		logic [BYTE_W-1:0]    data;
		logic [COUNT_W-1:0]   count;
		bit                   typed;
		status_t              want;
	} plan_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [CMD_W-1:0]     cmd;
	logic [ADDR_W-1:0]    byte_address;
	logic [BYTE_W-1:0]    byte_value;
	logic [COUNT_W-1:0]   bit_count;
	logic                 out_valid;
	logic                 out_stall;
	logic [VALUE_W-1:0]   value;
	logic [POS_W-1:0]     bits_remaining;
	logic                 overrun;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [PADDR_W-1:0]   paddr;
	logic [PDATA_W-1:0]   pwdata;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;

	// Shadow state of the reader. The written map keeps stimulus away from
	// store bytes that hold garbage after reset.
	logic [BYTE_W-1:0]    shadow_bytes [STORE_BYTES];
	bit                   written [STORE_BYTES];
	int unsigned          shadow_pos;
	logic                 shadow_over;
	logic [SIZE_W-1:0]    shadow_size;

	status_t              pending_status [$];
	int                   mismatches;

	// Shared between the sender and the receiver: calm turns off all random idling,
	// squeeze_req asks the receiver for one long hold-off.
	bit                   calm;
	bit                   squeeze_req;

	msb_first_bit_reader uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.byte_address   (byte_address),
		.byte_value     (byte_value),
		.bit_count      (bit_count),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.value          (value),
		.bits_remaining (bits_remaining),
		.overrun        (overrun),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Hard stop in case a handshake never completes.
	initial begin
		#6_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic note_mismatch(input string what, input status_t want, input status_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("[%0t] %s: expected value %h remaining %0d overrun %b, got %h %0d %b",
				$realtime, what, want.value, want.remaining, want.overrun,
				got.value, got.remaining, got.overrun);
		end
	endtask

	// Sizes above the store depth act as the full store.
	function automatic int unsigned eff_bytes();
		return (shadow_size > STORE_BYTES) ? STORE_BYTES : shadow_size;
	endfunction

	// Bit extraction, most significant first. Bits whose byte lies past the
	// valid size read as zero, leave the position where it is and mark overrun.
	// Only a read commits position and flag; a peek leaves both alone.
	function automatic logic [VALUE_W-1:0] pull_bits(input logic [COUNT_W-1:0] count,
			input bit commit);
		int unsigned          p;
		int unsigned          n;
		int unsigned          lim;
		logic                 over;
		logic                 b;
		logic [VALUE_W-1:0]   acc;
		p    = shadow_pos;
		over = shadow_over;
		lim  = eff_bytes();
		acc  = '0;
		if (count == 0) return '0;
		n = (count > MAX_READ_BITS) ? MAX_READ_BITS : count;
		for (int i = 0; i < n; i++) begin
			if ((p >> 3) >= lim) begin
				over = 1'b1;
				b    = 1'b0;
			end else begin
				b = shadow_bytes[p >> 3][7 - (p % 8)];
				p++;
			end
			acc = {acc[VALUE_W-2:0], b};
		end
		if (commit) begin
			shadow_pos  = p;
			shadow_over = over;
		end
		return acc;
	endfunction

	// First store byte inside the valid size that a read or peek of this many
	// bits would touch without it ever having been written, or -1.
	function automatic int first_hole(input logic [COUNT_W-1:0] count);
		int unsigned p;
		int unsigned n;
		int unsigned lim;
		p   = shadow_pos;
		lim = eff_bytes();
		n   = (count > MAX_READ_BITS) ? MAX_READ_BITS : count;
		for (int i = 0; i < n; i++) begin
			if ((p >> 3) >= lim) return -1;
			if (!written[p >> 3]) return int'(p >> 3);
			p++;
		end
		return -1;
	endfunction

	// Applies one accepted input word to the shadow state and returns the
	// result word the block must produce for it.
	function automatic status_t advance_reader(input logic [CMD_W-1:0] op,
			input logic [ADDR_W-1:0] addr, input logic [BYTE_W-1:0] data,
			input logic [COUNT_W-1:0] count);
		status_t     res;
		int unsigned total;
		int unsigned np;
		res   = '0;
		total = eff_bytes() * 8;
		case (op)
			CMD_WRITE: begin
				shadow_bytes[addr] = data;
				written[addr]      = 1'b1;
			end
			CMD_READ: res.value = pull_bits(count, 1'b1);
			CMD_PEEK: res.value = pull_bits(count, 1'b0);
			CMD_SKIP: begin
				// A skip saturates at the end, which also pulls back a position
				// left beyond the end by a smaller buffer_size.
				if (count != 0) begin
					np = shadow_pos + count;
					if (np > total) begin
						np          = total;
						shadow_over = 1'b1;
					end
					shadow_pos = np;
				end
			end
			CMD_REWIND: begin
				shadow_pos  = 0;
				shadow_over = 1'b0;
			end
			default: ;
		endcase
		res.remaining = (shadow_pos >= total) ? '0 : POS_W'(total - shadow_pos);
		res.overrun   = shadow_over;
		return res;
	endfunction

	// Offers one word, idling first at random, and returns the prediction once
	// the block has taken it. Returns at the falling edge after acceptance.
	task automatic offer_word(input logic [CMD_W-1:0] op, input logic [ADDR_W-1:0] addr,
			input logic [BYTE_W-1:0] data, input logic [COUNT_W-1:0] count,
			output status_t predicted);
		while (!calm && $urandom_range(0, 99) < 35) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		cmd          <= op;
		byte_address <= addr;
		byte_value   <= data;
		bit_count    <= count;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predicted = advance_reader(op, addr, data, count);
		@(negedge clk);
	endtask

	// Drops valid and waits until every predicted word has come out.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending_status.size() != 0);
	endtask

	// Writes buffer_size over the configuration port and reads it back.
	// Upper data bits are junk; only the low SIZE_W bits are the register.
	task automatic program_size(input logic [SIZE_W-1:0] bytes);
		logic [PDATA_W-1:0] word;
		status_t            want;
		status_t            got;
		word                = $urandom();
		word[SIZE_W-1:0]    = bytes;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= SIZE_REG_ADDR;
		pwdata  <= word;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		shadow_size = bytes;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata[SIZE_W-1:0] !== bytes) begin
			want = '0;
			got  = '0;
			want.value = VALUE_W'(bytes);
			got.value  = VALUE_W'(prdata[SIZE_W-1:0]);
			note_mismatch("buffer_size read back", want, got);
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic plan_row_t word_row(input logic [CMD_W-1:0] op,
			input logic [ADDR_W-1:0] addr, input logic [BYTE_W-1:0] data,
			input logic [COUNT_W-1:0] count);
		plan_row_t r;
		r.kind  = ROW_WORD;
		r.op    = op;
		r.addr  = addr;
		r.data  = data;
		r.count = count;
		r.typed = 1'b0;
		r.want  = '0;
		return r;
	endfunction

	function automatic plan_row_t known_row(input logic [CMD_W-1:0] op,
			input logic [ADDR_W-1:0] addr, input logic [BYTE_W-1:0] data,
			input logic [COUNT_W-1:0] count, input logic [VALUE_W-1:0] v,
			input logic [POS_W-1:0] rem, input logic ovr);
		plan_row_t r;
		r       = word_row(op, addr, data, count);
		r.typed = 1'b1;
		r.want  = '{value: v, remaining: rem, overrun: ovr};
		return r;
	endfunction

	function automatic plan_row_t size_row(input logic [SIZE_W-1:0] bytes);
		plan_row_t r;
		r       = word_row(CMD_WRITE, '0, '0, COUNT_W'(bytes));
		r.kind  = ROW_SIZE;
		return r;
	endfunction

	// Receiver: stalls at random except in the calm stretch, and once holds
	// off for a long count of cycles so the block backs up into its input.
	initial begin
		int hold_left;
		bit squeeze_done;
		hold_left    = 0;
		squeeze_done = 1'b0;
		out_stall    = 1'b0;
		forever begin
			@(negedge clk);
			if (squeeze_req && !squeeze_done) begin
				squeeze_done = 1'b1;
				hold_left    = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (calm) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(0, 99) < 35);
			end
		end
	end

	// Result checker: every accepted output word is matched against the
	// oldest prediction still waiting.
	always @(posedge clk) begin
		status_t want;
		status_t got;
		if (arst_n && out_valid && !out_stall) begin
			got = '{value: value, remaining: bits_remaining, overrun: overrun};
			if (pending_status.size() == 0) begin
				note_mismatch("result word with nothing expected", '0, got);
			end else begin
				want = pending_status.pop_front();
				if (got.value !== want.value || got.remaining !== want.remaining ||
						got.overrun !== want.overrun) begin
					note_mismatch("result word", want, got);
				end
			end
		end
	end

	initial begin
		plan_row_t            plan [$];
		status_t              predicted;
		int                   phase_sizes [PHASES];
		int                   serial;
		int                   pick;
		int                   hole;
		int unsigned          front;
		logic [CMD_W-1:0]     op_v;
		logic [ADDR_W-1:0]    addr_v;
		logic [BYTE_W-1:0]    byte_v;
		logic [COUNT_W-1:0]   cnt_v;

		// Every input known from time zero; reset asserted, then released on a falling edge.
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		cmd          = '0;
		byte_address = '0;
		byte_value   = '0;
		bit_count    = '0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		calm         = 1'b0;
		squeeze_req  = 1'b0;
		mismatches   = 0;
		shadow_pos   = 0;
		shadow_over  = 1'b0;
		shadow_size  = '0;
		foreach (written[i]) written[i] = 1'b0;
		foreach (shadow_bytes[i]) shadow_bytes[i] = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed table. After reset the size is zero, so every read runs off
		// the end at once; zero counts, the sticky flag and peeks that leave
		// it alone can be read off directly.
		plan.push_back(known_row(CMD_READ,      '0, '0, 16'd0,     '0, 16'd0, 1'b0));
		plan.push_back(known_row(CMD_PEEK,      '0, '0, 16'd5,     '0, 16'd0, 1'b0));
		plan.push_back(known_row(CMD_READ,      '0, '0, 16'd32,    '0, 16'd0, 1'b1));
		plan.push_back(known_row(CMD_REWIND,    '0, '0, 16'd0,     '0, 16'd0, 1'b0));
		plan.push_back(known_row(CMD_SKIP,      '0, '0, 16'd0,     '0, 16'd0, 1'b0));
		plan.push_back(known_row(CMD_SKIP,      '0, '0, 16'd1,     '0, 16'd0, 1'b1));
		plan.push_back(known_row(CMD_UNUSED_HI, '0, '0, 16'd9,     '0, 16'd0, 1'b1));
		plan.push_back(known_row(CMD_UNUSED_LO, '0, '0, 16'd9,     '0, 16'd0, 1'b1));
		plan.push_back(known_row(CMD_REWIND,    '0, '0, 16'd0,     '0, 16'd0, 1'b0));
		// Load the first bytes and the last address of the store.
		plan.push_back(known_row(CMD_WRITE, 12'd0,    8'hFF, 16'd0, '0, 16'd0, 1'b0));
		plan.push_back(known_row(CMD_WRITE, 12'd1,    8'h00, 16'd0, '0, 16'd0, 1'b0));
		plan.push_back(known_row(CMD_WRITE, 12'd2,    8'hA5, 16'd0, '0, 16'd0, 1'b0));
		plan.push_back(known_row(CMD_WRITE, 12'd3,    8'h3C, 16'd0, '0, 16'd0, 1'b0));
		plan.push_back(known_row(CMD_WRITE, 12'd4,    8'h80, 16'd0, '0, 16'd0, 1'b0));
		plan.push_back(known_row(CMD_WRITE, 12'hFFF,  8'hFF, 16'd0, '0, 16'd0, 1'b0));
		// Four valid bytes: a full 32-bit read, then a peek far past the end,
		// which must not raise the flag.
		plan.push_back(size_row(13'd4));
		plan.push_back(word_row(CMD_READ,   '0, '0, 16'd32));
		plan.push_back(known_row(CMD_PEEK,   '0, '0, 16'hFFFF, '0, 16'd0,  1'b0));
		plan.push_back(known_row(CMD_REWIND, '0, '0, 16'd0,    '0, 16'd32, 1'b0));
		plan.push_back(word_row(CMD_READ,   '0, '0, 16'd1));
		plan.push_back(word_row(CMD_PEEK,   '0, '0, 16'd40));
		plan.push_back(word_row(CMD_SKIP,   '0, '0, 16'd20));
		// Shrinking the size leaves the position beyond the end: a read only
		// flags overrun and a skip pulls the position back to the end.
		plan.push_back(size_row(13'd1));
		plan.push_back(known_row(CMD_READ, '0, '0, 16'd3, '0, 16'd0, 1'b1));
		plan.push_back(known_row(CMD_SKIP, '0, '0, 16'd1, '0, 16'd0, 1'b1));
		// The largest register value acts as the full store.
		plan.push_back(size_row(13'h1FFF));
		plan.push_back(word_row(CMD_READ,   '0, '0, 16'd32));
		plan.push_back(known_row(CMD_SKIP,   '0, '0, 16'hFFFF, '0, 16'd0,     1'b1));
		plan.push_back(known_row(CMD_REWIND, '0, '0, 16'd0,    '0, 16'd32768, 1'b0));

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_SIZE) begin
				wait_drained();
				program_size(plan[i].count[SIZE_W-1:0]);
			end else begin
				offer_word(plan[i].op, plan[i].addr, plan[i].data, plan[i].count, predicted);
				pending_status.push_back(plan[i].typed ? plan[i].want : predicted);
			end
		end

		// Random phases, each under its own buffer_size, the extremes included.
		phase_sizes = '{0, 1, $urandom_range(2, 16), $urandom_range(17, 80),
			STORE_BYTES, 8191, $urandom_range(81, 700), 2};
		serial = 0;
		for (int ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			program_size(SIZE_W'(phase_sizes[ph]));
			for (int k = 0; k < WORDS_PER_PHASE; k++) begin
				calm = (serial >= 250 && serial < 400);
				if (serial == 600) squeeze_req = 1'b1;
				serial++;

				// Unused fields carry random junk on every word.
				pick   = $urandom_range(0, 99);
				op_v   = CMD_W'($urandom());
				addr_v = ADDR_W'($urandom());
				byte_v = BYTE_W'($urandom());
				cnt_v  = COUNT_W'($urandom());
				if (pick < 22) begin
					op_v = CMD_WRITE;
					// Mostly fill the bytes just ahead of the position.
					if ($urandom_range(0, 4) != 0) begin
						front = (shadow_pos >> 3) + $urandom_range(0, 8);
						if (front > STORE_BYTES - 1) front = STORE_BYTES - 1;
						addr_v = ADDR_W'(front);
					end
				end else if (pick < 74) begin
					op_v = (pick < 62) ? CMD_READ : CMD_PEEK;
					if ($urandom_range(0, 6) != 0) cnt_v = COUNT_W'($urandom_range(0, 33));
				end else if (pick < 88) begin
					op_v = CMD_SKIP;
					if ($urandom_range(0, 4) != 0) cnt_v = COUNT_W'($urandom_range(0, 24));
				end else if (pick < 95) begin
					op_v = CMD_REWIND;
				end else begin
					op_v = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
				end

				// A read or peek that would touch a never-written byte becomes the write
				// that fills it, so the stream keeps advancing over loaded data.
				if (op_v == CMD_READ || op_v == CMD_PEEK) begin
					hole = first_hole(cnt_v);
					if (hole >= 0) begin
						op_v   = CMD_WRITE;
						addr_v = ADDR_W'(hole);
					end
				end

				offer_word(op_v, addr_v, byte_v, cnt_v, predicted);
				pending_status.push_back(predicted);
			end
		end
		calm = 1'b0;

		// Let every result word come out, then allow a full read's latency for
		// anything unexpected to show up.
		wait_drained();
		repeat (40) @(negedge clk);

		if (mismatches == 0 && pending_status.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/msbr_pkg.sv
hw/rtl/msbr_ram.sv
hw/rtl/msbr_ctrl.sv
hw/rtl/msbr_dp.sv
hw/rtl/msb_first_bit_reader.sv
tb/tb_top.sv
